// ----- rtl/hdm_pkg.sv -----
package hdm_pkg;

    // Default sizes of the descriptor table.
    localparam int DEF_MAX_ENTRIES     = 64;
    localparam int DEF_DESCRIPTOR_BITS = 256;

    // Fixed field widths of the two streams.
    localparam int DESC_IN_W  = 256;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int DISTANCE_W = 9;
    localparam int M_TDATA_W  = 16;

    localparam logic [DISTANCE_W-1:0] LIMIT_RESET = 9'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // input beat accepted this cycle
        logic rd_issue;  // read the next table row for the scan
        logic res_load;  // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_end;  // every stored row has been read
        logic pipe_busy; // compare pipeline still holds rows
    } stat_t;

endpackage

// ----- rtl/hdm_ctrl.sv -----
module hdm_ctrl
    import hdm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  action_t act_in,
    output logic    m_tvalid,
    input  logic    m_tready,
    output cmd_t    cmd,
    input  stat_t   stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    assign s_tready     = (state_reg == S_IDLE);
    assign m_tvalid     = m_tvalid_reg;
    assign cmd.load     = s_tvalid && (state_reg == S_IDLE);
    assign cmd.rd_issue = (state_reg == S_SCAN) && !stat.addr_end;
    assign cmd.res_load = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (cmd.load) begin
                        state_reg <= (act_in == ACT_QUERY) ? S_SCAN : S_FINISH;
                    end
                end
                S_SCAN: begin
                    if (stat.addr_end) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!stat.pipe_busy) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (cmd.res_load) begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/hdm_datapath.sv -----
module hdm_datapath
    import hdm_pkg::*;
#(
    parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
    parameter int DESCRIPTOR_BITS = DEF_DESCRIPTOR_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [DISTANCE_W-1:0] cfg_wdata,
    input  action_t               act_in,
    input  logic [DESC_IN_W-1:0]  desc_in,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output status_t               m_status,
    output logic [INDEX_W-1:0]    m_index,
    output logic [DISTANCE_W-1:0] m_distance
);

    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int NUM_LANES = (DESCRIPTOR_BITS + 63) / 64;
    localparam int PAD_W     = NUM_LANES * 64;

    // Population count of one 64-bit lane as a tree of narrow adders.
    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

    logic [DESCRIPTOR_BITS-1:0] mem [MAX_ENTRIES];

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           rd_addr_reg;
    logic [DISTANCE_W-1:0]      limit_reg;
    action_t                    op_reg;
    logic                       found_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       full_reg;
    logic [DESCRIPTOR_BITS-1:0] desc_reg;
    logic [DESCRIPTOR_BITS-1:0] rdata_reg;
    logic [IDX_W-1:0]           idx1_reg;
    logic [IDX_W-1:0]           idx2_reg;
    logic [6:0]                 lane_cnt_reg [NUM_LANES];
    logic [IDX_W-1:0]           best_idx_reg;
    logic [DISTANCE_W-1:0]      best_dist_reg;
    status_t                    m_status_reg;
    logic [INDEX_W-1:0]         m_index_reg;
    logic [DISTANCE_W-1:0]      m_distance_reg;

    logic                  table_full;
    logic                  do_append;
    logic [PAD_W-1:0]      diff;
    logic [DISTANCE_W-1:0] dist_sum;
    logic                  better;
    logic [IDX_W+5:0]      idx_ext;
    status_t               res_status;
    logic [INDEX_W-1:0]    res_index;
    logic [DISTANCE_W-1:0] res_distance;

    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign do_append  = cmd.load && (act_in == ACT_APPEND) && !table_full;
    assign diff       = PAD_W'(rdata_reg ^ desc_reg);

    assign stat.addr_end  = (rd_addr_reg == count_reg);
    assign stat.pipe_busy = v1_reg || v2_reg;

    always_comb begin
        dist_sum = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            dist_sum = dist_sum + DISTANCE_W'(lane_cnt_reg[l]);
        end
    end

    // Strict less-than keeps the earliest entry on a tie.
    assign better = (dist_sum <= limit_reg) && (!found_reg || (dist_sum < best_dist_reg));

    // Slot numbers wrap to the width of the result field.
    assign idx_ext = {6'd0, best_idx_reg};

    always_comb begin
        unique case (op_reg)
            ACT_APPEND: begin
                res_status   = full_reg ? ST_FULL : ST_DONE;
                res_index    = full_reg ? '0 : idx_ext[INDEX_W-1:0];
                res_distance = '0;
            end
            ACT_QUERY: begin
                res_status   = found_reg ? ST_DONE : ST_NO_MATCH;
                res_index    = found_reg ? idx_ext[INDEX_W-1:0] : '0;
                res_distance = found_reg ? best_dist_reg : '0;
            end
            ACT_CLEAR, ACT_NONE: begin
                res_status   = ST_DONE;
                res_index    = '0;
                res_distance = '0;
            end
        endcase
    end

    // Descriptor table: one write port for appends, one registered read port for scans.
    always_ff @(posedge aclk) begin
        if (do_append) begin
            mem[count_reg[IDX_W-1:0]] <= desc_in[DESCRIPTOR_BITS-1:0];
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[rd_addr_reg[IDX_W-1:0]];
            idx1_reg  <= rd_addr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_addr_reg <= '0;
            limit_reg   <= LIMIT_RESET;
            op_reg      <= ACT_NONE;
            found_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            v1_reg <= cmd.rd_issue;
            v2_reg <= v1_reg;
            if (cmd.load) begin
                op_reg      <= act_in;
                rd_addr_reg <= '0;
                found_reg   <= 1'b0;
                if (act_in == ACT_CLEAR) begin
                    count_reg <= '0;
                end else if (do_append) begin
                    count_reg <= count_reg + 1'b1;
                end
            end else begin
                if (cmd.rd_issue) begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
                if (v2_reg && better) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            desc_reg     <= desc_in[DESCRIPTOR_BITS-1:0];
            full_reg     <= table_full;
            best_idx_reg <= count_reg[IDX_W-1:0];
        end else if (v2_reg && better) begin
            best_idx_reg  <= idx2_reg;
            best_dist_reg <= dist_sum;
        end
        if (v1_reg) begin
            idx2_reg <= idx1_reg;
            for (int l = 0; l < NUM_LANES; l++) begin
                lane_cnt_reg[l] <= popcount64(diff[l*64 +: 64]);
            end
        end
        if (cmd.res_load) begin
            m_status_reg   <= res_status;
            m_index_reg    <= res_index;
            m_distance_reg <= res_distance;
        end
    end

    assign m_status   = m_status_reg;
    assign m_index    = m_index_reg;
    assign m_distance = m_distance_reg;

endmodule

// ----- rtl/hamming_descriptor_matcher.sv -----
// Channel   | Ports    | Beat contents
// ----------+----------+-------------------------------------------------------------
// command   | s_t*     | tuser: action[1:0]; tdata: desc_word0..desc_word3 (bits 255:0)
// result    | m_t*     | tuser: status[1:0]; tdata: match_index[5:0], match_distance[14:6]
// config    | cfg_w*   | cfg_wdata: match_limit[8:0]
//
// A clear or append beat goes from the idle state straight to the finish state, its result
// registered on leaving it. A query scans the N stored entries and drains the pipeline before
// it finishes: the memory delivers one row per cycle into a two-stage popcount and compare pipeline.
// Reset empties the table and sets match_limit to 64; the memory itself is not cleared.
// A stalled result beat holds in the output register; a new command beat is accepted while
// it waits, and the next result waits in the block until the output register frees.
module hamming_descriptor_matcher
    import hdm_pkg::*;
#(
    parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
    parameter int DESCRIPTOR_BITS = DEF_DESCRIPTOR_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write: match_limit.
    input  logic                  cfg_wen,
    input  logic [DISTANCE_W-1:0] cfg_wdata,

    // Command stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DESC_IN_W-1:0]  s_tdata,   // desc_word0, desc_word1, desc_word2, desc_word3
    input  logic [ACTION_W-1:0]   s_tuser,   // action

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // match_index, match_distance, one zero pad bit
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    cmd_t                  cmd;
    stat_t                 stat;
    action_t               act_in;
    status_t               m_status;
    logic [INDEX_W-1:0]    m_index;
    logic [DISTANCE_W-1:0] m_distance;

    assign act_in = action_t'(s_tuser);

    // The controller sequences the clear, append and query operations and owns the
    // handshakes; the datapath holds the table, the scan pipeline and the result.
    hdm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .act_in   (act_in),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    hdm_datapath #(
        .MAX_ENTRIES     (MAX_ENTRIES),
        .DESCRIPTOR_BITS (DESCRIPTOR_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .act_in     (act_in),
        .desc_in    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_status   (m_status),
        .m_index    (m_index),
        .m_distance (m_distance)
    );

    assign m_tdata = {1'b0, m_distance, m_index};
    assign m_tuser = m_status;

endmodule
